// ===== src/zda_pkg.sv =====
// ----------------------------------------------------------------------------
// ZDA parser package
// Shared types, character codes and helper functions for the NMEA ZDA
// sentence parser.
// ----------------------------------------------------------------------------
package zda_pkg;

	// ASCII codes that steer the sentence parser
	localparam logic [7:0] ChDollar = 8'h24;
	localparam logic [7:0] ChStar   = 8'h2A;
	localparam logic [7:0] ChComma  = 8'h2C;
	localparam logic [7:0] ChDot    = 8'h2E;
	localparam logic [7:0] ChCr     = 8'h0D;
	localparam logic [7:0] ChZero   = 8'h30;
	localparam logic [7:0] ChNine   = 8'h39;
	localparam logic [7:0] ChUpperA = 8'h41;
	localparam logic [7:0] ChUpperF = 8'h46;
	localparam logic [7:0] ChG      = 8'h47;
	localparam logic [7:0] ChP      = 8'h50;
	localparam logic [7:0] ChZ      = 8'h5A;
	localparam logic [7:0] ChD      = 8'h44;

	// Field numbers inside the sentence body
	localparam logic [2:0] FldHeader = 3'd0;
	localparam logic [2:0] FldTime   = 3'd1;
	localparam logic [2:0] FldDay    = 3'd2;
	localparam logic [2:0] FldMonth  = 3'd3;
	localparam logic [2:0] FldYear   = 3'd4;

	// Parser states
	typedef enum logic [3:0] {
		ST_WAIT_DOLLAR,
		ST_EXPECT_G,
		ST_EXPECT_P,
		ST_EXPECT_Z,
		ST_EXPECT_D,
		ST_EXPECT_A,
		ST_FIELDS,
		ST_WAIT_STAR,
		ST_HEX_HIGH,
		ST_HEX_LOW
	} state_t;

	// One received character
	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_item_t;

	// One decoded date and time
	typedef struct packed {
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic        checksum_verified;
	} zda_item_t;

	// Completed sentence as held by the parser; time is kept as six BCD digits
	typedef struct packed {
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [23:0] time_bcd;
		logic        verified;
	} fix_t;

	// Hex digit decode: bit 4 is the valid flag, bits 3:0 the value
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= ChZero && c <= ChNine) begin
			r = {1'b1, c[3:0]};
		end else if (c >= ChUpperA && c <= ChUpperF) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	// Two BCD digits to a binary value below 100
	function automatic logic [6:0] bcd2_to_bin(input logic [3:0] hi, input logic [3:0] lo);
		logic [6:0] h;
		h = {3'b000, hi};
		return (h << 3) + (h << 1) + {3'b000, lo};
	endfunction

	// Highest digit count per field
	function automatic logic [2:0] digit_limit(input logic [2:0] fi);
		logic [2:0] r;
		case (fi)
			FldTime:  r = 3'd6;
			FldDay:   r = 3'd2;
			FldMonth: r = 3'd2;
			FldYear:  r = 3'd4;
			default:  r = 3'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== src/zda_stream_if.sv =====
// ----------------------------------------------------------------------------
// ZDA stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface zda_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/zda_field_parser.sv =====
// ----------------------------------------------------------------------------
// ZDA field parser
// Header match, field scan, running XOR and checksum check; one character
// per step, raising a completion flag with the decoded fields.
// ----------------------------------------------------------------------------
module zda_field_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        char_s1,
	output logic              emit,
	output zda_pkg::fix_t     fix
);

	zda_pkg::state_t state_q, state_d;
	logic [2:0]  fi_q, fi_d;
	logic [2:0]  cnt_q, cnt_d;
	logic        dp_q, dp_d;
	logic [7:0]  xor_q, xor_d;
	logic [23:0] time_q, time_d;
	logic [6:0]  day_q, day_d;
	logic [6:0]  month_q, month_d;
	logic [13:0] year_q, year_d;

	logic       is_digit, is_comma, is_dot, field_ok, take_digit;
	logic [3:0] digit;
	logic [4:0] hex;
	logic       hex_hi_ok, hex_lo_ok;

	// Character classes
	assign is_digit = (char_s1 >= zda_pkg::ChZero) && (char_s1 <= zda_pkg::ChNine);
	assign is_comma = (char_s1 == zda_pkg::ChComma);
	assign is_dot   = (char_s1 == zda_pkg::ChDot);
	assign digit    = char_s1[3:0];
	assign hex      = zda_pkg::hex_decode(char_s1);
	assign hex_hi_ok = hex[4] && (hex[3:0] == xor_q[7:4]);
	assign hex_lo_ok = hex[4] && (hex[3:0] == xor_q[3:0]);

	// Whether a character is legal inside the field list
	always_comb begin
		field_ok   = 1'b0;
		take_digit = 1'b0;
		if (fi_q > zda_pkg::FldYear) begin
			field_ok = 1'b0;
		end else if (fi_q == zda_pkg::FldHeader) begin
			field_ok = is_comma;
		end else if (is_comma) begin
			field_ok = 1'b1;
		end else if (is_dot && fi_q == zda_pkg::FldTime) begin
			field_ok = !dp_q;
		end else if (is_digit) begin
			if (fi_q == zda_pkg::FldTime && dp_q) begin
				field_ok = 1'b1;
			end else begin
				field_ok   = (cnt_q < zda_pkg::digit_limit(fi_q));
				take_digit = field_ok;
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		if (step) begin
			unique case (state_q)
				zda_pkg::ST_WAIT_DOLLAR: begin
					if (char_s1 == zda_pkg::ChDollar) state_d = zda_pkg::ST_EXPECT_G;
				end
				zda_pkg::ST_EXPECT_G: begin
					state_d = (char_s1 == zda_pkg::ChG) ? zda_pkg::ST_EXPECT_P
					                                    : zda_pkg::ST_WAIT_DOLLAR;
				end
				zda_pkg::ST_EXPECT_P: begin
					state_d = (char_s1 == zda_pkg::ChP) ? zda_pkg::ST_EXPECT_Z
					                                    : zda_pkg::ST_WAIT_DOLLAR;
				end
				zda_pkg::ST_EXPECT_Z: begin
					state_d = (char_s1 == zda_pkg::ChZ) ? zda_pkg::ST_EXPECT_D
					                                    : zda_pkg::ST_WAIT_DOLLAR;
				end
				zda_pkg::ST_EXPECT_D: begin
					state_d = (char_s1 == zda_pkg::ChD) ? zda_pkg::ST_EXPECT_A
					                                    : zda_pkg::ST_WAIT_DOLLAR;
				end
				zda_pkg::ST_EXPECT_A: begin
					state_d = (char_s1 == zda_pkg::ChUpperA) ? zda_pkg::ST_FIELDS
					                                         : zda_pkg::ST_WAIT_DOLLAR;
				end
				zda_pkg::ST_FIELDS: begin
					if (!field_ok) begin
						state_d = zda_pkg::ST_WAIT_DOLLAR;
					end else if (is_comma && fi_q == zda_pkg::FldYear) begin
						state_d = zda_pkg::ST_WAIT_STAR;
					end
				end
				zda_pkg::ST_WAIT_STAR: begin
					if (char_s1 == zda_pkg::ChStar) begin
						state_d = zda_pkg::ST_HEX_HIGH;
					end else if (char_s1 == zda_pkg::ChCr) begin
						state_d = zda_pkg::ST_WAIT_DOLLAR;
					end
				end
				zda_pkg::ST_HEX_HIGH: begin
					state_d = hex_hi_ok ? zda_pkg::ST_HEX_LOW : zda_pkg::ST_WAIT_DOLLAR;
				end
				zda_pkg::ST_HEX_LOW: begin
					state_d = zda_pkg::ST_WAIT_DOLLAR;
				end
				default: begin
					state_d = zda_pkg::ST_WAIT_DOLLAR;
				end
			endcase
		end
	end

	// Field registers, checksum and completion
	always_comb begin
		fi_d    = fi_q;
		cnt_d   = cnt_q;
		dp_d    = dp_q;
		xor_d   = xor_q;
		time_d  = time_q;
		day_d   = day_q;
		month_d = month_q;
		year_d  = year_q;
		emit    = 1'b0;
		if (step) begin
			unique case (state_q)
				zda_pkg::ST_WAIT_DOLLAR: begin
					if (char_s1 == zda_pkg::ChDollar) xor_d = 8'h00;
				end
				zda_pkg::ST_EXPECT_G, zda_pkg::ST_EXPECT_P, zda_pkg::ST_EXPECT_Z,
				zda_pkg::ST_EXPECT_D: begin
					xor_d = xor_q ^ char_s1;
				end
				zda_pkg::ST_EXPECT_A: begin
					xor_d = xor_q ^ char_s1;
					if (char_s1 == zda_pkg::ChUpperA) begin
						fi_d  = zda_pkg::FldHeader;
						cnt_d = 3'd0;
						dp_d  = 1'b0;
					end
				end
				zda_pkg::ST_FIELDS: begin
					xor_d = xor_q ^ char_s1;
					if (field_ok && is_comma) begin
						// Open the next field with an empty value
						fi_d  = fi_q + 3'd1;
						cnt_d = 3'd0;
						dp_d  = 1'b0;
						case (fi_q)
							zda_pkg::FldHeader: time_d  = '0;
							zda_pkg::FldTime:   day_d   = '0;
							zda_pkg::FldDay:    month_d = '0;
							zda_pkg::FldMonth:  year_d  = '0;
							default: ;
						endcase
					end else if (field_ok && is_dot) begin
						dp_d = 1'b1;
					end else if (take_digit) begin
						cnt_d = cnt_q + 3'd1;
						case (fi_q)
							zda_pkg::FldTime:  time_d  = {time_q[19:0], digit};
							zda_pkg::FldDay:   day_d   = (day_q << 3) + (day_q << 1)
							                             + {3'b000, digit};
							zda_pkg::FldMonth: month_d = (month_q << 3) + (month_q << 1)
							                             + {3'b000, digit};
							zda_pkg::FldYear:  year_d  = (year_q << 3) + (year_q << 1)
							                             + {10'd0, digit};
							default: ;
						endcase
					end
				end
				zda_pkg::ST_WAIT_STAR: begin
					if (char_s1 == zda_pkg::ChCr) begin
						emit = 1'b1;
					end else if (char_s1 != zda_pkg::ChStar) begin
						xor_d = xor_q ^ char_s1;
					end
				end
				zda_pkg::ST_HEX_HIGH: ;
				zda_pkg::ST_HEX_LOW: begin
					emit = hex_lo_ok;
				end
				default: ;
			endcase
		end
	end

	assign fix.year     = year_q;
	assign fix.month    = month_q;
	assign fix.day      = day_q;
	assign fix.time_bcd = time_q;
	assign fix.verified = (state_q == zda_pkg::ST_HEX_LOW);

	// Registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= zda_pkg::ST_WAIT_DOLLAR;
			fi_q    <= '0;
			cnt_q   <= '0;
			dp_q    <= 1'b0;
			xor_q   <= '0;
			time_q  <= '0;
			day_q   <= '0;
			month_q <= '0;
			year_q  <= '0;
		end else begin
			state_q <= state_d;
			fi_q    <= fi_d;
			cnt_q   <= cnt_d;
			dp_q    <= dp_d;
			xor_q   <= xor_d;
			time_q  <= time_d;
			day_q   <= day_d;
			month_q <= month_d;
			year_q  <= year_d;
		end
	end

	// A sentence completes only from the checksum or terminator states.
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (state_q == zda_pkg::ST_WAIT_STAR || state_q == zda_pkg::ST_HEX_LOW))
		else $error("completion outside terminator states");

	// After a completion the parser hunts for the next sentence start.
	a_emit_next: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (state_q == zda_pkg::ST_WAIT_DOLLAR))
		else $error("parser did not return to idle after completion");

	// The digit count never passes the widest field limit.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == zda_pkg::ST_FIELDS |-> (cnt_q <= 3'd6 && fi_q <= zda_pkg::FldYear))
		else $error("field counters out of range");

endmodule

// ===== src/zda_result_reg.sv =====
// ----------------------------------------------------------------------------
// ZDA result register
// Splits the BCD time into hour, minute and second and holds one result
// until the downstream side takes it.
// ----------------------------------------------------------------------------
module zda_result_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  zda_pkg::fix_t     fix,
	zda_stream_if.source      zda
);

	logic                valid_q;
	zda_pkg::zda_item_t  item_q;
	zda_pkg::zda_item_t  item_d;

	// Convert the completed sentence into the result format
	always_comb begin
		item_d.year              = fix.year;
		item_d.month             = fix.month;
		item_d.day               = fix.day;
		item_d.hour              = zda_pkg::bcd2_to_bin(fix.time_bcd[23:20], fix.time_bcd[19:16]);
		item_d.minute            = zda_pkg::bcd2_to_bin(fix.time_bcd[15:12], fix.time_bcd[11:8]);
		item_d.second            = zda_pkg::bcd2_to_bin(fix.time_bcd[7:4], fix.time_bcd[3:0]);
		item_d.checksum_verified = fix.verified;
	end

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (zda.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= item_d;
		end
	end

	assign zda.valid   = valid_q;
	assign zda.payload = item_q;

endmodule

// ===== src/nmea_zda_sentence_parser_unit.sv =====
// ----------------------------------------------------------------------------
// NMEA ZDA sentence parser
// Parses "$GPZDA" sentences from a character stream and reports date and
// time once per completed sentence.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                   Per transaction
//  rx       in   rx_byte                                   one character
//  zda      out  year, month, day, hour, minute, second,   one completed
//                checksum_verified                         sentence
//
// One character is taken per cycle while no result waits; a result is valid
// once its last character has passed the input register and the parser step.
// The rate is set by the input register feeding the parser step.
// Reset clears the parser to hunt for '$' and empties both registers.
// While a result waits on zda, the parser step holds and rx accepts at most
// one more character into its input register.
module nmea_zda_sentence_parser_unit (
	input  logic          clk,
	input  logic          arst_n,
	zda_stream_if.sink    rx,
	zda_stream_if.source  zda
);

	logic          valid_s1;
	logic [7:0]    char_s1;
	logic          advance;
	logic          step;
	logic          emit;
	zda_pkg::fix_t fix;

	// The parser steps whenever a character is held and the result register has room
	assign advance  = !zda.valid || zda.ready;
	assign step     = valid_s1 && advance;
	assign rx.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			char_s1 <= rx.payload.rx_byte;
		end
	end

	zda_field_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.char_s1 (char_s1),
		.emit    (emit),
		.fix     (fix)
	);

	zda_result_reg u_result (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (emit),
		.fix    (fix),
		.zda    (zda)
	);

	// A held result blocks the parser step, so no completion can overwrite it.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(zda.valid && !zda.ready) |-> !step)
		else $error("parser stepped while result was held");

	// Input back-pressure only comes from a full input register behind a held result.
	a_ready_src: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> (valid_s1 && zda.valid && !zda.ready))
		else $error("input stalled without cause");

endmodule

// ===== test/tb_nmea_zda_sentence_parser_unit.sv =====
// ----------------------------------------------------------------------------
// NMEA ZDA sentence parser testbench
// Feeds character streams into the parser and checks every decoded date and
// time against a behavioral prediction kept inside the bench. Directed
// sentences cover field extremes, header errors, bad characters, digit
// limits, the text after the year and checksum digits. A backpressure test
// and a long random stream of mostly well-formed sentences follow.
// ----------------------------------------------------------------------------
module tb_nmea_zda_sentence_parser_unit;

	// Characters used only when building stimulus
	localparam logic [7:0] ChLf  = 8'h0A;
	localparam logic [7:0] ChPad = 8'h58;

	// How a built sentence is terminated
	typedef enum int {
		TAIL_SUM,
		TAIL_CR,
		TAIL_BAD_HIGH,
		TAIL_BAD_LOW,
		TAIL_BAD_DIGIT,
		TAIL_OPEN
	} ending_t;

	// Receiver stall patterns
	typedef enum int {
		SINK_OPEN,
		SINK_COIN,
		SINK_SPARSE,
		SINK_BUSY
	} sink_mode_t;

	logic clk;
	logic arst_n;

	zda_stream_if #(.payload_t(zda_pkg::rx_item_t))  rx_if ();
	zda_stream_if #(.payload_t(zda_pkg::zda_item_t)) zda_if ();

	nmea_zda_sentence_parser_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if.sink),
		.zda    (zda_if.source)
	);

	// Predicted parser state
	zda_pkg::state_t parse_state;
	logic [2:0]  field_num;
	logic [19:0] field_acc;
	logic [2:0]  digits;
	logic        in_fraction;
	logic [7:0]  running_sum;
	logic [19:0] time_val;
	logic [6:0]  day_val;
	logic [6:0]  month_val;
	logic [13:0] year_val;

	zda_pkg::zda_item_t zda_expected[$];
	logic [7:0]  line_buf[$];
	int          mismatch_count = 0;
	int          chars_accepted = 0;
	int          fixes_predicted = 0;
	int          burst_left = 0;
	bit          tx_steady = 1'b0;
	bit          hold_request = 1'b0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog
	initial begin
		#(8 * 500000);
		$display("FAILURE");
		$finish;
	end

	// Value of an uppercase hex digit, or -1 for any other character.
	function automatic int nibble_of(input logic [7:0] c);
		if (c >= zda_pkg::ChZero && c <= zda_pkg::ChNine) begin
			return int'(c - zda_pkg::ChZero);
		end
		if (c >= zda_pkg::ChUpperA && c <= zda_pkg::ChUpperF) begin
			return int'(c - zda_pkg::ChUpperA) + 10;
		end
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? zda_pkg::ChZero + n : zda_pkg::ChUpperA + n - 8'd10;
	endfunction

	// XOR over everything after the leading '$' of the line being built.
	function automatic logic [7:0] line_xor();
		logic [7:0] x;
		x = '0;
		for (int i = 1; i < line_buf.size(); i++) begin
			x = x ^ line_buf[i];
		end
		return x;
	endfunction

	// Digit count for a field: mostly full, sometimes short, rarely too long.
	function automatic int field_len(input int limit);
		if ($urandom_range(0, 19) == 0) begin
			return limit + 1;
		end
		if ($urandom_range(0, 3) == 0) begin
			return $urandom_range(0, limit);
		end
		return limit;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// Advance the predicted parser by one accepted character.
	task automatic parse_zda_char(input logic [7:0] b);
		zda_pkg::zda_item_t fix;
		int        h;
		int        limit;
		logic      ok;
		logic      done;
		logic      verified;
		done = 1'b0;
		verified = 1'b0;
		chars_accepted++;
		case (parse_state)
			zda_pkg::ST_WAIT_DOLLAR: begin
				if (b == zda_pkg::ChDollar) begin
					running_sum = '0;
					parse_state = zda_pkg::ST_EXPECT_G;
				end
			end
			zda_pkg::ST_EXPECT_G: begin
				running_sum = running_sum ^ b;
				parse_state = (b == zda_pkg::ChG) ? zda_pkg::ST_EXPECT_P
				                                  : zda_pkg::ST_WAIT_DOLLAR;
			end
			zda_pkg::ST_EXPECT_P: begin
				running_sum = running_sum ^ b;
				parse_state = (b == zda_pkg::ChP) ? zda_pkg::ST_EXPECT_Z
				                                  : zda_pkg::ST_WAIT_DOLLAR;
			end
			zda_pkg::ST_EXPECT_Z: begin
				running_sum = running_sum ^ b;
				parse_state = (b == zda_pkg::ChZ) ? zda_pkg::ST_EXPECT_D
				                                  : zda_pkg::ST_WAIT_DOLLAR;
			end
			zda_pkg::ST_EXPECT_D: begin
				running_sum = running_sum ^ b;
				parse_state = (b == zda_pkg::ChD) ? zda_pkg::ST_EXPECT_A
				                                  : zda_pkg::ST_WAIT_DOLLAR;
			end
			zda_pkg::ST_EXPECT_A: begin
				running_sum = running_sum ^ b;
				if (b == zda_pkg::ChUpperA) begin
					field_num = zda_pkg::FldHeader;
					field_acc = '0;
					digits = '0;
					in_fraction = 1'b0;
					parse_state = zda_pkg::ST_FIELDS;
				end else begin
					parse_state = zda_pkg::ST_WAIT_DOLLAR;
				end
			end
			zda_pkg::ST_FIELDS: begin
				running_sum = running_sum ^ b;
				ok = 1'b1;
				case (field_num)
					zda_pkg::FldTime:                    limit = 6;
					zda_pkg::FldDay, zda_pkg::FldMonth:  limit = 2;
					zda_pkg::FldYear:                    limit = 4;
					default:                             limit = 0;
				endcase
				if (field_num > zda_pkg::FldYear) begin
					ok = 1'b0;
				end else if (field_num == zda_pkg::FldHeader) begin
					// Only a comma may follow the header.
					if (b == zda_pkg::ChComma) begin
						field_num = zda_pkg::FldTime;
						field_acc = '0;
						digits = '0;
						in_fraction = 1'b0;
					end else begin
						ok = 1'b0;
					end
				end else if (b == zda_pkg::ChComma) begin
					case (field_num)
						zda_pkg::FldTime:  time_val = field_acc;
						zda_pkg::FldDay:   day_val = field_acc[6:0];
						zda_pkg::FldMonth: month_val = field_acc[6:0];
						default: begin
							year_val = field_acc[13:0];
							parse_state = zda_pkg::ST_WAIT_STAR;
						end
					endcase
					field_num = field_num + 3'd1;
					field_acc = '0;
					digits = '0;
					in_fraction = 1'b0;
				end else if (b == zda_pkg::ChDot && field_num == zda_pkg::FldTime) begin
					if (in_fraction) begin
						ok = 1'b0;
					end else begin
						in_fraction = 1'b1;
					end
				end else if (b >= zda_pkg::ChZero && b <= zda_pkg::ChNine) begin
					// Fraction digits of the time are dropped.
					if (!(field_num == zda_pkg::FldTime && in_fraction)) begin
						if (digits >= limit) begin
							ok = 1'b0;
						end else begin
							field_acc = field_acc * 20'd10
							            + {12'd0, b - zda_pkg::ChZero};
							digits = digits + 3'd1;
						end
					end
				end else begin
					ok = 1'b0;
				end
				if (!ok) begin
					parse_state = zda_pkg::ST_WAIT_DOLLAR;
				end
			end
			zda_pkg::ST_WAIT_STAR: begin
				if (b == zda_pkg::ChStar) begin
					parse_state = zda_pkg::ST_HEX_HIGH;
				end else if (b == zda_pkg::ChCr) begin
					parse_state = zda_pkg::ST_WAIT_DOLLAR;
					done = 1'b1;
				end else begin
					running_sum = running_sum ^ b;
				end
			end
			zda_pkg::ST_HEX_HIGH: begin
				h = nibble_of(b);
				if (h < 0 || h != running_sum[7:4]) begin
					parse_state = zda_pkg::ST_WAIT_DOLLAR;
				end else begin
					parse_state = zda_pkg::ST_HEX_LOW;
				end
			end
			zda_pkg::ST_HEX_LOW: begin
				h = nibble_of(b);
				parse_state = zda_pkg::ST_WAIT_DOLLAR;
				if (h >= 0 && h == running_sum[3:0]) begin
					done = 1'b1;
					verified = 1'b1;
				end
			end
			default: begin
				parse_state = zda_pkg::ST_WAIT_DOLLAR;
			end
		endcase

		// A completed sentence yields one date and time.
		if (done) begin
			fix.year = year_val;
			fix.month = month_val;
			fix.day = day_val;
			fix.hour = 7'(time_val / 20'd10000);
			fix.minute = 7'((time_val % 20'd10000) / 20'd100);
			fix.second = 7'(time_val % 20'd100);
			fix.checksum_verified = verified;
			zda_expected.push_back(fix);
			fixes_predicted++;
		end
	endtask

	// Compare one delivered date and time with the oldest prediction.
	task automatic check_zda(input zda_pkg::zda_item_t got);
		zda_pkg::zda_item_t want;
		if (zda_expected.size() == 0) begin
			report_mismatch($sformatf("result with none expected, year %0d", got.year));
			return;
		end
		want = zda_expected.pop_front();
		if (got.year !== want.year)
			report_mismatch($sformatf("year: expected %0d, got %0d", want.year, got.year));
		if (got.month !== want.month)
			report_mismatch($sformatf("month: expected %0d, got %0d", want.month, got.month));
		if (got.day !== want.day)
			report_mismatch($sformatf("day: expected %0d, got %0d", want.day, got.day));
		if (got.hour !== want.hour)
			report_mismatch($sformatf("hour: expected %0d, got %0d", want.hour, got.hour));
		if (got.minute !== want.minute)
			report_mismatch($sformatf("minute: expected %0d, got %0d", want.minute,
				got.minute));
		if (got.second !== want.second)
			report_mismatch($sformatf("second: expected %0d, got %0d", want.second,
				got.second));
		if (got.checksum_verified !== want.checksum_verified)
			report_mismatch($sformatf("checksum_verified: expected %0d, got %0d",
				want.checksum_verified, got.checksum_verified));
	endtask

	// Both channels are observed at the same edge, input first.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_if.valid === 1'b1 && rx_if.ready === 1'b1) begin
				parse_zda_char(rx_if.payload.rx_byte);
			end
			if (zda_if.valid === 1'b1 && zda_if.ready === 1'b1) begin
				check_zda(zda_if.payload);
			end
		end
	end

	// Receiver: changing stall patterns, plus a long hold-off on request.
	initial begin
		int         hold_left;
		int         mode_left;
		int         phase;
		sink_mode_t sink_mode;
		hold_left = 0;
		mode_left = 0;
		phase = 0;
		sink_mode = SINK_OPEN;
		zda_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 400;
			end
			if (mode_left == 0) begin
				sink_mode = sink_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(32, 256);
			end
			mode_left--;
			phase++;
			if (hold_left > 0) begin
				hold_left--;
				zda_if.ready <= 1'b0;
			end else begin
				case (sink_mode)
					SINK_OPEN:   zda_if.ready <= 1'b1;
					SINK_COIN:   zda_if.ready <= 1'($urandom_range(0, 1));
					SINK_SPARSE: zda_if.ready <= (phase % 4 == 0);
					default:     zda_if.ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// Offer one character and wait until the transaction completes. Outside
	// steady mode the sender works in bursts with random gaps between them.
	task automatic send_char(input logic [7:0] c);
		int gap;
		if (!tx_steady) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					rx_if.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
		end
		rx_if.valid <= 1'b1;
		rx_if.payload.rx_byte <= c;
		do @(posedge clk); while (rx_if.ready !== 1'b1);
	endtask

	task automatic send_line();
		foreach (line_buf[i]) begin
			send_char(line_buf[i]);
		end
		line_buf.delete();
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			line_buf.push_back(s[i]);
		end
	endtask

	task automatic put_digits(input int n);
		repeat (n) line_buf.push_back(zda_pkg::ChZero + 8'($urandom_range(0, 9)));
	endtask

	// Append text after the year so that the sentence XOR becomes target.
	task automatic put_forced_sum(input logic [7:0] target);
		logic [7:0] x;
		x = line_xor();
		while ((x ^ target) == zda_pkg::ChStar || (x ^ target) == zda_pkg::ChCr) begin
			line_buf.push_back(ChPad);
			x = x ^ ChPad;
		end
		line_buf.push_back(x ^ target);
	endtask

	// Terminate the line: good or damaged checksum, bare return, or nothing.
	task automatic put_end(input ending_t e);
		logic [7:0] sum;
		logic [7:0] bad;
		sum = line_xor();
		case (e)
			TAIL_SUM, TAIL_BAD_HIGH, TAIL_BAD_LOW: begin
				if (e == TAIL_BAD_HIGH) sum[7:4] = sum[7:4] ^ 4'($urandom_range(1, 15));
				if (e == TAIL_BAD_LOW) sum[3:0] = sum[3:0] ^ 4'($urandom_range(1, 15));
				line_buf.push_back(zda_pkg::ChStar);
				line_buf.push_back(hex_char(sum[7:4]));
				line_buf.push_back(hex_char(sum[3:0]));
			end
			TAIL_BAD_DIGIT: begin
				do bad = 8'($urandom_range(0, 255)); while (nibble_of(bad) >= 0);
				line_buf.push_back(zda_pkg::ChStar);
				if ($urandom_range(0, 1) == 0) begin
					line_buf.push_back(bad);
					line_buf.push_back(hex_char(sum[3:0]));
				end else begin
					line_buf.push_back(hex_char(sum[7:4]));
					line_buf.push_back(bad);
				end
			end
			default: ;
		endcase
		if (e != TAIL_OPEN) begin
			line_buf.push_back(zda_pkg::ChCr);
			line_buf.push_back(ChLf);
		end
	endtask

	task automatic send_zda(input string body, input ending_t e);
		line_buf.delete();
		put_text(body);
		put_end(e);
		send_line();
	endtask

	// One random sentence: mostly well formed, with occasional damage.
	task automatic send_random_zda();
		int      r;
		int      idx;
		ending_t e;
		logic [7:0] c;
		line_buf.delete();
		r = $urandom_range(0, 19);
		put_text(r == 0 ? "$GPGGA" : (r == 1 ? "$GPVTG" : "$GPZDA"));
		line_buf.push_back(zda_pkg::ChComma);
		put_digits(field_len(6));
		if ($urandom_range(0, 1) == 0) begin
			line_buf.push_back(zda_pkg::ChDot);
			put_digits($urandom_range(0, 5));
			if ($urandom_range(0, 29) == 0) line_buf.push_back(zda_pkg::ChDot);
		end
		line_buf.push_back(zda_pkg::ChComma);
		put_digits(field_len(2));
		line_buf.push_back(zda_pkg::ChComma);
		put_digits(field_len(2));
		line_buf.push_back(zda_pkg::ChComma);
		put_digits(field_len(4));
		line_buf.push_back(zda_pkg::ChComma);

		// Local zone fields, arbitrary printable text, or nothing
		r = $urandom_range(0, 9);
		if (r < 6) begin
			put_digits(2);
			line_buf.push_back(zda_pkg::ChComma);
			put_digits(2);
		end else if (r < 8) begin
			repeat ($urandom_range(1, 6)) begin
				do c = 8'($urandom_range(32, 126)); while (c == zda_pkg::ChStar);
				line_buf.push_back(c);
			end
		end
		if ($urandom_range(0, 3) == 0) put_forced_sum(8'($urandom_range(0, 255)));

		// Occasional corruption of one character
		if ($urandom_range(0, 9) == 0) begin
			idx = $urandom_range(1, line_buf.size() - 1);
			line_buf[idx] = 8'($urandom_range(0, 255));
		end

		r = $urandom_range(0, 99);
		if (r < 60)      e = TAIL_SUM;
		else if (r < 80) e = TAIL_CR;
		else if (r < 86) e = TAIL_BAD_HIGH;
		else if (r < 92) e = TAIL_BAD_LOW;
		else if (r < 97) e = TAIL_BAD_DIGIT;
		else             e = TAIL_OPEN;
		put_end(e);
		send_line();

		// Line noise between sentences
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
		end
	endtask

	// Field extremes, empty fields, long fraction and hex letters in the sum.
	task automatic test_field_extremes();
		logic [7:0] targets[4];
		targets = '{8'hAF, 8'hFA, 8'h00, 8'hFF};
		send_zda("$GPZDA,235959.99,31,12,2024,00,00", TAIL_SUM);
		send_zda("$GPZDA,999999.999999999,99,99,9999,", TAIL_SUM);
		send_zda("$GPZDA,000000,00,00,0000,", TAIL_CR);
		send_zda("$GPZDA,,,,,", TAIL_SUM);
		send_zda("$GPZDA,7,5,3,1,", TAIL_CR);
		send_zda("$GPZDA,.5,,,,", TAIL_SUM);
		foreach (targets[i]) begin
			line_buf.delete();
			put_text("$GPZDA,120000,01,02,2003,");
			put_forced_sum(targets[i]);
			put_end(TAIL_SUM);
			send_line();
		end
	endtask

	// Wrong header letters drop the sentence; a '$' there is consumed.
	task automatic test_header_mismatch();
		send_zda("$GPGGA,123519,4807.038,N", TAIL_SUM);
		send_zda("$GPVTG,054.7,T", TAIL_CR);
		send_zda("$XPZDA,1,2,3,4,", TAIL_CR);
		send_zda("$GXZDA,1,2,3,4,", TAIL_CR);
		send_zda("$GPXDA,1,2,3,4,", TAIL_CR);
		send_zda("$GPZXA,1,2,3,4,", TAIL_CR);
		send_zda("$GPZDX,1,2,3,4,", TAIL_CR);
		send_zda("$G$GPZDA,1,2,3,4,", TAIL_CR);
		send_zda("$GPZDA,101112,13,14,1516,", TAIL_SUM);
	endtask

	// Bad characters inside the fields, including early terminators.
	task automatic test_field_characters();
		send_zda("$GPZDAX,1,2,3,4,", TAIL_CR);
		send_zda("$GPZDA,12a456,01,01,2000,", TAIL_CR);
		send_zda("$GPZDA,123456.1.2,01,01,2000,", TAIL_CR);
		send_zda("$GPZDA,123456,0.1,01,2000,", TAIL_CR);
		send_zda("$GPZDA,123456,01$GPZDA,1,2,3,4,", TAIL_CR);
		send_zda("$GPZDA,123456,01,01", TAIL_SUM);
		send_zda("$GPZDA,123456,01,01,2000", TAIL_CR);
		send_zda("$GPZDA,123456,01,01,2000,", TAIL_CR);
	endtask

	// One digit beyond the limit of each field.
	task automatic test_digit_limits();
		send_zda("$GPZDA,1234567,01,01,2000,", TAIL_CR);
		send_zda("$GPZDA,123456,123,01,2000,", TAIL_CR);
		send_zda("$GPZDA,123456,01,123,2000,", TAIL_CR);
		send_zda("$GPZDA,123456,01,01,12345,", TAIL_CR);
	endtask

	// Text after the year is ignored but summed; an open sentence swallows
	// the next one, whose terminator then completes the first.
	task automatic test_after_year();
		send_zda("$GPZDA,010203,04,05,2006,+05,30,xyz", TAIL_SUM);
		line_buf.delete();
		put_text("$GPZDA,010203,04,05,2006,");
		put_text("$GPZDA,111111,11,11,2011,");
		put_end(TAIL_SUM);
		send_line();
	endtask

	// Damaged checksum digits, lowercase hex among them.
	task automatic test_checksum_digits();
		send_zda("$GPZDA,202020,20,10,2020,", TAIL_BAD_HIGH);
		send_zda("$GPZDA,202020,20,10,2020,", TAIL_BAD_LOW);
		send_zda("$GPZDA,202020,20,10,2020,", TAIL_BAD_DIGIT);
		line_buf.delete();
		put_text("$GPZDA,202020,20,10,2020,");
		put_forced_sum(8'hCD);
		put_text("*cd");
		line_buf.push_back(zda_pkg::ChCr);
		send_line();
		send_zda("$GPZDA,202020,20,10,2020,", TAIL_SUM);
	endtask

	// The receiver holds off while the sender keeps offering characters.
	task automatic test_backpressure();
		hold_request = 1'b1;
		tx_steady = 1'b1;
		for (int i = 0; i < 6; i++) begin
			send_zda($sformatf("$GPZDA,%02d%02d%02d,%02d,%02d,%04d,", i, i + 10, i + 20,
				i + 1, i + 2, 2000 + i), (i % 2 == 0) ? TAIL_SUM : TAIL_CR);
		end
		tx_steady = 1'b0;
	endtask

	task automatic test_random_stream();
		int chars_start;
		chars_start = chars_accepted;
		while (chars_accepted - chars_start < 500) begin
			send_random_zda();
		end
	endtask

	// Test sequence
	initial begin
		rx_if.valid <= 1'b0;
		rx_if.payload <= '0;
		arst_n = 1'b0;
		parse_state = zda_pkg::ST_WAIT_DOLLAR;
		field_num = zda_pkg::FldHeader;
		field_acc = '0;
		digits = '0;
		in_fraction = 1'b0;
		running_sum = '0;
		time_val = '0;
		day_val = '0;
		month_val = '0;
		year_val = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_header_mismatch();
		test_field_characters();
		test_digit_limits();
		test_after_year();
		test_checksum_digits();
		test_backpressure();
		test_random_stream();

		// Drain outstanding results, then allow for the output latency.
		rx_if.valid <= 1'b0;
		while (zda_expected.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (zda_expected.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", zda_expected.size()));
		end
		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/zda_pkg.sv
src/zda_stream_if.sv
src/zda_field_parser.sv
src/zda_result_reg.sv
src/nmea_zda_sentence_parser_unit.sv
test/tb_nmea_zda_sentence_parser_unit.sv
